### hdl/key_click_hold_event_detector_macros.svh
// Assertion macros for the key click and hold event detector.
`ifndef KEY_CLICK_HOLD_EVENT_DETECTOR_MACROS_SVH
`define KEY_CLICK_HOLD_EVENT_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define KCHD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define KCHD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define KCHD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define KCHD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/kchd_pkg.sv
// Shared types, constants and helper functions of the key click and hold event detector.
package kchd_pkg;

   // Timer width and the width used to compare timers against 16-bit thresholds.
   localparam int TIME_BITS = 16;
   localparam int CMP_W     = (TIME_BITS > 16) ? TIME_BITS : 16;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [CMP_W-1:0]     cmp_type;

   localparam time_type TIME_MAX = '1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_POLL_PERIOD     = 3'd0;
   localparam csr_idx_type CSR_CLICK_THRESHOLD = 3'd1;
   localparam csr_idx_type CSR_HOLD_THRESHOLD  = 3'd2;
   localparam csr_idx_type CSR_REPEAT_PERIOD   = 3'd3;
   localparam csr_idx_type CSR_CLICK_GAP       = 3'd4;

   // Key modes.
   typedef enum logic [2:0] {
      MODE_RELEASE  = 3'd0,
      MODE_PREPRESS = 3'd1,
      MODE_PRELONG  = 3'd2,
      MODE_LONGHOLD = 3'd3,
      MODE_MULTI    = 3'd4
   } mode_type;

   // Configuration register set.
   typedef struct packed {
      logic [7:0]  poll_period;
      logic [15:0] click_threshold;
      logic [15:0] hold_threshold;
      logic [15:0] repeat_period;
      logic [15:0] click_gap;
   } cfg_type;

   // One result.
   typedef struct packed {
      logic        press_event;
      logic        long_start_event;
      logic        hold_repeat_event;
      logic        long_release_event;
      logic        multi_click_event;
      logic        release_event;
      logic [7:0]  click_count;
      logic [15:0] hold_time;
   } evt_type;

   // Timer advance that saturates at the timer maximum.
   function automatic time_type sat_add(input time_type a, input logic [7:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + (TIME_BITS+1)'(b);
      return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
   endfunction

   // Repeat reload value, limited to what the timer can hold.
   function automatic time_type reload_value(input logic [15:0] period);
      cmp_type ext;
      ext = CMP_W'(period);
      return (ext > CMP_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(ext);
   endfunction

   // Held time as reported, limited to 16 bits.
   function automatic logic [15:0] hold_report(input time_type held);
      cmp_type ext;
      ext = CMP_W'(held);
      return (ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
   endfunction

   // Timer strictly above a 16-bit threshold.
   function automatic logic above(input time_type t, input logic [15:0] thr);
      return CMP_W'(t) > CMP_W'(thr);
   endfunction

endpackage

### hdl/key_click_hold_event_detector.sv
// Top level of the key click and hold event detector.
//
// Each request is one polling tick carrying the sampled level of one key; each
// request gives exactly one result with the event flags, the click count of
// the current series and the last captured hold time. One request is taken
// every clock cycle while the result register is free or being read; the
// state update runs on the request held in the input register and its
// result lands in the result register, from which it is presented. Build one
// instance per key. Configuration writes are taken at any time but belong in
// idle periods.
`include "key_click_hold_event_detector_macros.svh"

module key_click_hold_event_detector
   import kchd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_pressed,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_press_event,
   output logic        rsp_long_start_event,
   output logic        rsp_hold_repeat_event,
   output logic        rsp_long_release_event,
   output logic        rsp_multi_click_event,
   output logic        rsp_release_event,
   output logic [7:0]  rsp_click_count,
   output logic [15:0] rsp_hold_time,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type cfg;
   evt_type evt;

   logic    s1_valid_ff,  s1_valid_in;
   logic    s1_pressed_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   evt_type rsp_evt_ff;
   logic    s1_advance;

   // Configuration registers.
   kchd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: the input register moves on whenever the result register is free.
   assign s1_advance  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // State machine and timers.
   kchd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_advance),
      .pressed (s1_pressed_ff),
      .cfg     (cfg),
      .evt     (evt)
   );

   // Valid flags of the input and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the input and result registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_pressed_ff <= req_pressed;
      end
      if (s1_advance) begin
         rsp_evt_ff <= evt;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_press_event        = rsp_evt_ff.press_event;
   assign rsp_long_start_event   = rsp_evt_ff.long_start_event;
   assign rsp_hold_repeat_event  = rsp_evt_ff.hold_repeat_event;
   assign rsp_long_release_event = rsp_evt_ff.long_release_event;
   assign rsp_multi_click_event  = rsp_evt_ff.multi_click_event;
   assign rsp_release_event      = rsp_evt_ff.release_event;
   assign rsp_click_count        = rsp_evt_ff.click_count;
   assign rsp_hold_time          = rsp_evt_ff.hold_time;

   // A release is reported exactly with a long release or the end of a series.
   `KCHD_ASSERT_IMPLIES(a_release_pair, clock, reset, rsp_valid_ff,
      rsp_evt_ff.release_event ==
      (rsp_evt_ff.long_release_event || rsp_evt_ff.multi_click_event))

   // Mode-changing events never come together.
   `KCHD_ASSERT_IMPLIES(a_events_exclusive, clock, reset, rsp_valid_ff,
      $onehot0({rsp_evt_ff.press_event, rsp_evt_ff.long_start_event,
                rsp_evt_ff.long_release_event, rsp_evt_ff.multi_click_event}))

   // A waiting request is not lost while the result register is blocked.
   `KCHD_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp_ready,
      s1_valid_ff && rsp_valid_ff)

   // The input register accepts nothing while it is full and blocked.
   `KCHD_ASSERT_IMPLIES(a_no_overrun, clock, reset, s1_valid_ff && !s1_advance, !req_ready)

endmodule

### hdl/kchd_csr.sv
// Configuration registers of the key click and hold event detector.
module kchd_csr
   import kchd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; unknown indexes leave every register alone.
   assign csr_ready = 1'b1;

   // Decode the write index.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POLL_PERIOD:     cfg_in.poll_period     = csr_wdata[7:0];
            CSR_CLICK_THRESHOLD: cfg_in.click_threshold = csr_wdata;
            CSR_HOLD_THRESHOLD:  cfg_in.hold_threshold  = csr_wdata;
            CSR_REPEAT_PERIOD:   cfg_in.repeat_period   = csr_wdata;
            CSR_CLICK_GAP:       cfg_in.click_gap       = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_period     <= 8'd1;
         cfg_ff.click_threshold <= 16'd20;
         cfg_ff.hold_threshold  <= 16'd1000;
         cfg_ff.repeat_period   <= 16'd200;
         cfg_ff.click_gap       <= 16'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/kchd_core.sv
// Key state machine with its timers; computes one result per polling tick.
module kchd_core
   import kchd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    pressed,
   input  cfg_type cfg,
   output evt_type evt
);

   mode_type    mode_ff,        mode_in;
   time_type    press_time_ff,  press_time_in;
   time_type    gap_time_ff,    gap_time_in;
   time_type    repeat_time_ff, repeat_time_in;
   logic [7:0]  clicks_ff,      clicks_in;
   time_type    held_time_ff,   held_time_in;

   // Next state, timers and events for the current tick.
   always_comb begin
      mode_in        = mode_ff;
      repeat_time_in = repeat_time_ff;
      clicks_in      = clicks_ff;
      held_time_in   = held_time_ff;
      evt            = '0;

      // Press timer runs while pressed; release captures it out of long hold.
      if (!pressed) begin
         if (mode_ff == MODE_LONGHOLD) begin
            held_time_in = press_time_ff;
         end
         press_time_in = '0;
      end else begin
         press_time_in = sat_add(press_time_ff, cfg.poll_period);
      end

      // Gap timer runs only between clicks of a series.
      gap_time_in = (mode_ff == MODE_MULTI) ? sat_add(gap_time_ff, cfg.poll_period) : '0;

      unique case (mode_ff)
         MODE_RELEASE: begin
            clicks_in = '0;
            if (pressed) begin
               mode_in = MODE_PREPRESS;
            end
         end
         MODE_PREPRESS: begin
            if (!pressed) begin
               mode_in = MODE_RELEASE;
            end else if (above(press_time_in, cfg.click_threshold)) begin
               mode_in = MODE_PRELONG;
               evt.press_event = 1'b1;
            end
         end
         MODE_PRELONG: begin
            if (!pressed) begin
               mode_in = MODE_MULTI;
               if (clicks_ff != 8'hFF) begin
                  clicks_in = clicks_ff + 8'd1;
               end
            end else if (above(press_time_in, cfg.hold_threshold)) begin
               mode_in = MODE_LONGHOLD;
               repeat_time_in = reload_value(cfg.repeat_period);
               evt.long_start_event = 1'b1;
            end
         end
         MODE_LONGHOLD: begin
            // Repeat countdown stops at zero, then reloads with a repeat event.
            if (repeat_time_ff != '0) begin
               repeat_time_in = (repeat_time_ff > time_type'(cfg.poll_period)) ?
                                repeat_time_ff - time_type'(cfg.poll_period) : '0;
            end else begin
               repeat_time_in = reload_value(cfg.repeat_period);
               evt.hold_repeat_event = 1'b1;
            end
            if (!pressed) begin
               evt.long_release_event = 1'b1;
               evt.release_event      = 1'b1;
               mode_in = MODE_RELEASE;
            end
         end
         MODE_MULTI: begin
            if (above(gap_time_in, cfg.click_gap)) begin
               evt.multi_click_event = 1'b1;
               evt.release_event     = 1'b1;
               mode_in = MODE_RELEASE;
            end else if (above(press_time_in, cfg.click_threshold)) begin
               mode_in = MODE_PRELONG;
            end
         end
         default: begin
            mode_in = MODE_RELEASE;
         end
      endcase

      evt.click_count = clicks_in;
      evt.hold_time   = hold_report(held_time_in);
   end

   // State register, advanced once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_RELEASE;
         press_time_ff  <= '0;
         gap_time_ff    <= '0;
         repeat_time_ff <= '0;
         clicks_ff      <= '0;
         held_time_ff   <= '0;
      end else if (step) begin
         mode_ff        <= mode_in;
         press_time_ff  <= press_time_in;
         gap_time_ff    <= gap_time_in;
         repeat_time_ff <= repeat_time_in;
         clicks_ff      <= clicks_in;
         held_time_ff   <= held_time_in;
      end
   end

endmodule

### bench/kchd_event_checker.sv
// Event checker for the key click and hold detector: predicts every result and compares it.
`timescale 1ns / 100ps

module kchd_event_checker
   import kchd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_pressed,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_press_event,
   input  logic        rsp_long_start_event,
   input  logic        rsp_hold_repeat_event,
   input  logic        rsp_long_release_event,
   input  logic        rsp_multi_click_event,
   input  logic        rsp_release_event,
   input  logic [7:0]  rsp_click_count,
   input  logic [15:0] rsp_hold_time,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  csr_idx_type csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          pending_results
);

   // Register copy, as written through the configuration port.
   logic [7:0]  poll_cfg;
   logic [15:0] click_thr;
   logic [15:0] hold_thr;
   logic [15:0] repeat_cfg;
   logic [15:0] gap_cfg;

   // Key state, mirrored tick by tick.
   mode_type    key_mode;
   time_type    press_timer;
   time_type    gap_timer;
   time_type    repeat_timer;
   time_type    held_press;
   logic [7:0]  click_total;

   // Results predicted but not yet seen on the result channel.
   evt_type     expected_events[$];

   // Timers move on by one poll period and stick at their top value.
   function automatic time_type timer_advance(input time_type t);
      logic [TIME_BITS:0] sum;
      sum = t + poll_cfg;
      return (sum > TIME_MAX) ? TIME_MAX : sum[TIME_BITS-1:0];
   endfunction

   // The repeat timer reloads from the period register, limited to the timer range.
   function automatic time_type repeat_reload();
      return (repeat_cfg > TIME_MAX) ? TIME_MAX : time_type'(repeat_cfg);
   endfunction

   // One polling tick: updates the mirrored state and returns the events it raises.
   function automatic evt_type key_tick_events(input logic pressed);
      evt_type ev;
      ev = '0;

      if (!pressed) begin
         if (key_mode == MODE_LONGHOLD)
            held_press = press_timer;
         press_timer = '0;
      end else begin
         press_timer = timer_advance(press_timer);
      end

      if (key_mode == MODE_MULTI)
         gap_timer = timer_advance(gap_timer);
      else
         gap_timer = '0;

      case (key_mode)
         MODE_RELEASE: begin
            click_total = '0;
            if (pressed)
               key_mode = MODE_PREPRESS;
         end
         MODE_PREPRESS: begin
            if (!pressed) begin
               key_mode = MODE_RELEASE;
            end else if (press_timer > click_thr) begin
               key_mode = MODE_PRELONG;
               ev.press_event = 1'b1;
            end
         end
         MODE_PRELONG: begin
            if (!pressed) begin
               key_mode = MODE_MULTI;
               if (click_total != 8'hFF)
                  click_total = click_total + 8'd1;
            end else if (press_timer > hold_thr) begin
               key_mode = MODE_LONGHOLD;
               repeat_timer = repeat_reload();
               ev.long_start_event = 1'b1;
            end
         end
         MODE_LONGHOLD: begin
            // The countdown rests at zero for one tick, then fires and reloads.
            if (repeat_timer != '0) begin
               repeat_timer = (repeat_timer > poll_cfg) ? repeat_timer - poll_cfg : '0;
            end else begin
               repeat_timer = repeat_reload();
               ev.hold_repeat_event = 1'b1;
            end
            if (!pressed) begin
               ev.long_release_event = 1'b1;
               ev.release_event = 1'b1;
               key_mode = MODE_RELEASE;
            end
         end
         MODE_MULTI: begin
            if (gap_timer > gap_cfg) begin
               ev.multi_click_event = 1'b1;
               ev.release_event = 1'b1;
               key_mode = MODE_RELEASE;
            end else if (press_timer > click_thr) begin
               key_mode = MODE_PRELONG;
            end
         end
         default: begin
            key_mode = MODE_RELEASE;
         end
      endcase

      ev.click_count = click_total;
      ev.hold_time = (held_press > 16'hFFFF) ? 16'hFFFF : 16'(held_press);
      return ev;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Watch all three channels on each rising edge.
   always @(posedge clock) begin
      evt_type observed;
      evt_type oldest;
      if (reset) begin
         poll_cfg     = 8'd1;
         click_thr    = 16'd20;
         hold_thr     = 16'd1000;
         repeat_cfg   = 16'd200;
         gap_cfg      = 16'd300;
         key_mode     = MODE_RELEASE;
         press_timer  = '0;
         gap_timer    = '0;
         repeat_timer = '0;
         held_press   = '0;
         click_total  = '0;
         expected_events.delete();
      end else begin
         // Results are checked against the oldest prediction first.
         if (rsp_valid && rsp_ready) begin
            observed = {rsp_press_event, rsp_long_start_event, rsp_hold_repeat_event,
                        rsp_long_release_event, rsp_multi_click_event, rsp_release_event,
                        rsp_click_count, rsp_hold_time};
            if (expected_events.size() == 0) begin
               $display("%0t ns: result with no request outstanding, expected none, got %h",
                        $time, observed);
               mismatches++;
            end else begin
               oldest = expected_events.pop_front();
               check_field("press_event", oldest.press_event, observed.press_event);
               check_field("long_start_event", oldest.long_start_event,
                           observed.long_start_event);
               check_field("hold_repeat_event", oldest.hold_repeat_event,
                           observed.hold_repeat_event);
               check_field("long_release_event", oldest.long_release_event,
                           observed.long_release_event);
               check_field("multi_click_event", oldest.multi_click_event,
                           observed.multi_click_event);
               check_field("release_event", oldest.release_event, observed.release_event);
               check_field("click_count", oldest.click_count, observed.click_count);
               check_field("hold_time", oldest.hold_time, observed.hold_time);
            end
         end

         // Register writes; indexes beyond the last register are dropped.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POLL_PERIOD:     poll_cfg   = csr_wdata[7:0];
               CSR_CLICK_THRESHOLD: click_thr  = csr_wdata;
               CSR_HOLD_THRESHOLD:  hold_thr   = csr_wdata;
               CSR_REPEAT_PERIOD:   repeat_cfg = csr_wdata;
               CSR_CLICK_GAP:       gap_cfg    = csr_wdata;
               default: ;
            endcase
         end

         // Each accepted request yields exactly one result.
         if (req_valid && req_ready)
            expected_events.push_back(key_tick_events(req_pressed));
      end
      pending_results <= expected_events.size();
   end

endmodule

### bench/tb_key_click_hold_event_detector.sv
// Testbench top for the key click and hold detector: stimulus, idling, pressure and verdict.
`timescale 1ns / 100ps

module tb_key_click_hold_event_detector;
   import kchd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_pressed;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_press_event;
   logic        rsp_long_start_event;
   logic        rsp_hold_repeat_event;
   logic        rsp_long_release_event;
   logic        rsp_multi_click_event;
   logic        rsp_release_event;
   logic [7:0]  rsp_click_count;
   logic [15:0] rsp_hold_time;
   logic        csr_valid;
   logic        csr_ready;
   csr_idx_type csr_index;
   logic [15:0] csr_wdata;

   int mismatches;
   int pending_results;

   // Idling controls and bookkeeping, written by the stimulus process only.
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_requests;
   int ticks_sent;
   int press_span;
   int gap_span;

   // Key press pattern for the directed part: a press, a double click, then a long hold.
   localparam logic [16:0] TAP_PATTERN = 17'b11011000011111110;

   key_click_hold_event_detector dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_pressed            (req_pressed),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_press_event        (rsp_press_event),
      .rsp_long_start_event   (rsp_long_start_event),
      .rsp_hold_repeat_event  (rsp_hold_repeat_event),
      .rsp_long_release_event (rsp_long_release_event),
      .rsp_multi_click_event  (rsp_multi_click_event),
      .rsp_release_event      (rsp_release_event),
      .rsp_click_count        (rsp_click_count),
      .rsp_hold_time          (rsp_hold_time),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   kchd_event_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_pressed            (req_pressed),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_press_event        (rsp_press_event),
      .rsp_long_start_event   (rsp_long_start_event),
      .rsp_hold_repeat_event  (rsp_hold_repeat_event),
      .rsp_long_release_event (rsp_long_release_event),
      .rsp_multi_click_event  (rsp_multi_click_event),
      .rsp_release_event      (rsp_release_event),
      .rsp_click_count        (rsp_click_count),
      .rsp_hold_time          (rsp_hold_time),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .mismatches             (mismatches),
      .pending_results        (pending_results)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Safety net in case the block stops answering.
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      int served;
      served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != served) begin
            served = hold_requests;
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
         end
         rsp_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Offer one polling tick and wait until the block takes the request.
   task automatic offer_tick(input logic level);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_pressed = level;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      ticks_sent++;
   endtask

   // Stop offering and wait until every predicted result has been seen.
   task automatic settle();
      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [15:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Program all timing registers once the block has gone quiet.
   // The unused upper byte of the poll period write carries random bits.
   task automatic set_timing(input logic [7:0] pp, input logic [15:0] ct,
                             input logic [15:0] ht, input logic [15:0] rp,
                             input logic [15:0] gp);
      settle();
      write_reg(CSR_POLL_PERIOD, {8'($urandom), pp});
      write_reg(CSR_CLICK_THRESHOLD, ct);
      write_reg(CSR_HOLD_THRESHOLD, ht);
      write_reg(CSR_REPEAT_PERIOD, rp);
      write_reg(CSR_CLICK_GAP, gp);
   endtask

   // Short timings so that clicks, long holds and repeats all happen within a few ticks.
   task automatic random_timing();
      int pp;
      int ct;
      int ht;
      int rp;
      int gp;
      pp = $urandom_range(1, 6);
      ct = pp * $urandom_range(0, 4) + $urandom_range(0, pp - 1);
      ht = ct + pp * $urandom_range(0, 12);
      rp = pp * $urandom_range(0, 4) + $urandom_range(0, pp - 1);
      gp = pp * $urandom_range(0, 8) + $urandom_range(0, pp - 1);
      press_span = ht / pp + 3 * (rp / pp) + 6;
      gap_span = gp / pp + 4;
      set_timing(8'(pp), 16'(ct), 16'(ht), 16'(rp), 16'(gp));
   endtask

   // Mostly whole press and release runs of random length, with some random chatter.
   task automatic random_keying(input int target);
      int start;
      int n;
      start = ticks_sent;
      while (ticks_sent - start < target) begin
         if ($urandom_range(0, 9) < 8) begin
            n = $urandom_range(1, press_span);
            repeat (n) offer_tick(1'b1);
            n = $urandom_range(1, gap_span);
            repeat (n) offer_tick(1'b0);
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) offer_tick(1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pressed = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_POLL_PERIOD;
      csr_wdata = '0;
      hold_requests = 0;
      ticks_sent = 0;
      press_span = 4;
      gap_span = 4;
      set_idling(0, 0);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A tap that is too short under the reset timings.
      offer_tick(1'b1);
      offer_tick(1'b0);

      // Directed taps: press, double click ending on gap expiry, long hold with repeats.
      set_timing(8'd1, 16'd1, 16'd3, 16'd1, 16'd2);
      for (int i = 16; i >= 0; i--)
         offer_tick(TAP_PATTERN[i]);

      // Zero poll period: the timers stand still and the key never gets past pre-press.
      settle();
      write_reg(CSR_POLL_PERIOD, 16'hFF00);
      repeat (4) offer_tick(1'b1);
      offer_tick(1'b0);

      // A write beyond the last register must leave the settings alone.
      settle();
      write_reg(csr_idx_type'(CSR_CLICK_GAP + $urandom_range(1, 3)), 16'($urandom));
      write_reg(CSR_POLL_PERIOD, 16'h0001);
      repeat (3) offer_tick(1'b1);
      offer_tick(1'b0);

      // Random phases, one per idling pattern; the first one also backs up the block.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_idling(0, 0);
            1: set_idling(55, 0);
            2: set_idling(0, 55);
            default: set_idling(29, 29);
         endcase
         random_timing();
         if (phase == 0)
            hold_requests++;
         random_keying(150);
      end

      // Extreme settings: no press can ever pass the click threshold.
      set_idling(55, 55);
      set_timing(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      repeat (12) offer_tick(1'b1);
      repeat (30) offer_tick(1'($urandom_range(0, 1)));

      // Saturation run: click count, gap timer, press timer and reported hold time.
      set_idling(29, 29);
      set_timing(8'd255, 16'h0000, 16'd65000, 16'hFFFF, 16'hFFFF);
      offer_tick(1'b1);
      offer_tick(1'b1);
      offer_tick(1'b0);
      repeat (256) begin
         offer_tick(1'b1);
         offer_tick(1'b0);
      end
      repeat (260) offer_tick(1'b0);
      repeat (262) offer_tick(1'b1);
      offer_tick(1'b0);
      repeat (3) offer_tick(1'b0);

      settle();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### key_click_hold_event_detector.f
+incdir+hdl
hdl/kchd_pkg.sv
hdl/kchd_csr.sv
hdl/kchd_core.sv
hdl/key_click_hold_event_detector.sv
bench/kchd_event_checker.sv
bench/tb_key_click_hold_event_detector.sv
